/* sv/tti_pkg.sv */
// Constants, voltage ROM and helper functions for the thermistor table interpolator.
package tti_pkg;

   localparam int TABLE_POINTS = 33;
   localparam int ROM_POINTS   = 33;
   localparam int POINTS_USED  = (TABLE_POINTS > ROM_POINTS) ? ROM_POINTS :
                                 ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
   localparam int LAST_POINT   = POINTS_USED - 1;

   localparam int IDX_W   = $clog2(ROM_POINTS);
   localparam int VOLT_W  = 13;
   localparam int ALU_W   = VOLT_W + 1;
   localparam int TEMP_W  = 12;
   localparam int WHOLE_W = 8;

   // Widest interval is 70 mV, so 80 * num stays below 2**13.
   localparam int DIV_W   = 13;
   localparam int CNT_W   = $clog2(DIV_W + 1);

   localparam int FIRST_TEMP = -40;
   localparam int TEMP_STEP  = 5;

   localparam logic [VOLT_W-2:0] VOLT_ROM [ROM_POINTS] = '{
      12'd2440, 12'd2420, 12'd2400, 12'd2380, 12'd2350, 12'd2320, 12'd2270,
      12'd2230, 12'd2170, 12'd2110, 12'd2050, 12'd1990, 12'd1920, 12'd1860,
      12'd1800, 12'd1740, 12'd1680, 12'd1630, 12'd1590, 12'd1550, 12'd1510,
      12'd1480, 12'd1450, 12'd1430, 12'd1400, 12'd1380, 12'd1370, 12'd1350,
      12'd1340, 12'd1330, 12'd1320, 12'd1310, 12'd1300
   };

   typedef logic [IDX_W-1:0] idx_type;

   // Table voltage at a point, zero-extended to the ALU width.
   function automatic logic signed [ALU_W-1:0] volt_at(input idx_type idx);
      logic signed [ALU_W-1:0] val;
      val = '0;
      if (int'(idx) < ROM_POINTS) begin
         val = signed'({2'b00, VOLT_ROM[int'(idx)]});
      end
      return val;
   endfunction

   // Table temperature at a point in whole degrees.
   function automatic logic signed [WHOLE_W-1:0] temp_at(input idx_type idx);
      int t;
      t = FIRST_TEMP + TEMP_STEP * int'(idx);
      return WHOLE_W'(t);
   endfunction

endpackage

/* sv/thermistor_table_interpolator.sv */
// Sequence: an input at or above the first point is clamped by the high check, one at or
// below the last point by the low check that follows; an input inside an interval then runs
// the linear interval search plus a 13-step restoring divide, all on one shared subtractor.
// Throughput: one item at a time; the next item is accepted the cycle after the result is
// registered, even while that result is still stalled.
// Reset: synchronous, active high; clears the sequencer and the result valid only.
module thermistor_table_interpolator (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [tti_pkg::VOLT_W-1:0]       req_voltage_mv,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [tti_pkg::TEMP_W-1:0]       rsp_temp_sixteenths,
   output logic signed [tti_pkg::WHOLE_W-1:0]      rsp_whole_degrees,
   output logic                                    rsp_clamped
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHK_HI = 3'd1;
   localparam logic [2:0] ST_CHK_LO = 3'd2;
   localparam logic [2:0] ST_SEARCH = 3'd3;
   localparam logic [2:0] ST_NUM    = 3'd4;
   localparam logic [2:0] ST_DEN    = 3'd5;
   localparam logic [2:0] ST_DIV    = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   localparam tti_pkg::idx_type LAST_IDX = tti_pkg::IDX_W'(tti_pkg::LAST_POINT);
   localparam logic [tti_pkg::CNT_W-1:0] LAST_STEP = tti_pkg::CNT_W'(tti_pkg::DIV_W - 1);

   logic [2:0]                              state_ff, state_in;
   logic signed [tti_pkg::VOLT_W-1:0]       volt_ff, volt_in;
   tti_pkg::idx_type                        idx_ff, idx_in;
   logic [tti_pkg::DIV_W-1:0]               num_ff, num_in;
   logic [tti_pkg::DIV_W-1:0]               den_ff, den_in;
   logic [tti_pkg::DIV_W-1:0]               rem_ff, rem_in;
   logic [tti_pkg::DIV_W-1:0]               quo_ff, quo_in;
   logic [tti_pkg::CNT_W-1:0]               cnt_ff, cnt_in;
   logic                                    clamp_ff, clamp_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [tti_pkg::TEMP_W-1:0]       rsp_temp_ff, rsp_temp_in;
   logic signed [tti_pkg::WHOLE_W-1:0]      rsp_whole_ff, rsp_whole_in;
   logic                                    rsp_clamp_ff, rsp_clamp_in;

   // Shared subtractor
   logic signed [tti_pkg::ALU_W-1:0] alu_a, alu_b, alu_diff;
   logic                             alu_neg;

   logic                               req_take, rsp_free;
   logic [tti_pkg::DIV_W-1:0]          num_x80;
   logic signed [tti_pkg::WHOLE_W-1:0] base_temp;
   logic                               round_up;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign alu_diff = alu_a - alu_b;
   assign alu_neg  = alu_diff[tti_pkg::ALU_W-1];

   assign num_x80   = (num_ff << 6) + (num_ff << 4);
   assign base_temp = tti_pkg::temp_at(idx_ff);
   // Truncation toward zero rounds a negative inexact value up.
   assign round_up  = base_temp[tti_pkg::WHOLE_W-1] && ((rem_ff != '0) || (quo_ff[3:0] != '0));

   always_comb begin
      alu_a = signed'(tti_pkg::ALU_W'(volt_ff));
      alu_b = tti_pkg::volt_at('0);
      unique case (state_ff)
         ST_CHK_LO: begin
            alu_a = tti_pkg::volt_at(LAST_IDX);
            alu_b = signed'(tti_pkg::ALU_W'(volt_ff));
         end
         ST_SEARCH: begin
            alu_b = tti_pkg::volt_at(idx_ff + 1'b1);
         end
         ST_NUM: begin
            alu_a = tti_pkg::volt_at(idx_ff);
            alu_b = signed'(tti_pkg::ALU_W'(volt_ff));
         end
         ST_DEN: begin
            alu_a = tti_pkg::volt_at(idx_ff);
            alu_b = tti_pkg::volt_at(idx_ff + 1'b1);
         end
         ST_DIV: begin
            alu_a = signed'({1'b0, rem_ff[tti_pkg::DIV_W-2:0], quo_ff[tti_pkg::DIV_W-1]});
            alu_b = signed'({1'b0, den_ff});
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      volt_in      = volt_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      clamp_in     = clamp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_temp_in  = rsp_temp_ff;
      rsp_whole_in = rsp_whole_ff;
      rsp_clamp_in = rsp_clamp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               volt_in  = req_voltage_mv;
               idx_in   = '0;
               rem_in   = '0;
               quo_in   = '0;
               clamp_in = 1'b0;
               state_in = ST_CHK_HI;
            end
         end
         ST_CHK_HI: begin
            if (!alu_neg) begin
               clamp_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_CHK_LO;
            end
         end
         ST_CHK_LO: begin
            if (!alu_neg) begin
               idx_in   = LAST_IDX;
               clamp_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Earlier points were all above the input, so the first one at or
            // under it closes the interval.
            if (!alu_neg) begin
               state_in = ST_NUM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_NUM: begin
            num_in   = alu_diff[tti_pkg::DIV_W-1:0];
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in   = alu_diff[tti_pkg::DIV_W-1:0];
            quo_in   = num_x80;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!alu_neg) begin
               rem_in = alu_diff[tti_pkg::DIV_W-1:0];
            end else begin
               rem_in = {rem_ff[tti_pkg::DIV_W-2:0], quo_ff[tti_pkg::DIV_W-1]};
            end
            quo_in = {quo_ff[tti_pkg::DIV_W-2:0], !alu_neg};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = signed'({base_temp, 4'b0000})
                            + signed'({5'b00000, quo_ff[6:0]});
               rsp_whole_in = base_temp + signed'({5'b00000, quo_ff[6:4]})
                            + signed'({7'b0000000, round_up});
               rsp_clamp_in = clamp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      volt_ff      <= volt_in;
      idx_ff       <= idx_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      clamp_ff     <= clamp_in;
      rsp_temp_ff  <= rsp_temp_in;
      rsp_whole_ff <= rsp_whole_in;
      rsp_clamp_ff <= rsp_clamp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_temp_sixteenths = rsp_temp_ff;
   assign rsp_whole_degrees   = rsp_whole_ff;
   assign rsp_clamped         = rsp_clamp_ff;

   a_take_starts_check: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_CHK_HI)
      else $error("accepted item did not start the range check");

   a_search_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> idx_ff < LAST_IDX)
      else $error("interval search ran past the last point");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff <= LAST_STEP)
      else $error("divide ran too many steps");

   a_clamp_exact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clamp_ff |-> rsp_temp_ff == signed'({rsp_whole_ff, 4'b0000}))
      else $error("clamped result is not a whole table temperature");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_temp_ff >= -12'sd640 && rsp_temp_ff <= 12'sd1920)
      else $error("temperature outside table range");

endmodule

/* tb/sv/thermistor_table_interpolator_tb.sv */
// Self-checking testbench for the thermistor table interpolator.
module thermistor_table_interpolator_tb;

   localparam int CURVE_POINTS = (tti_pkg::TABLE_POINTS > 33) ? 33 :
                                 ((tti_pkg::TABLE_POINTS < 2) ? 2 : tti_pkg::TABLE_POINTS);
   localparam int DEG_STEP     = 5;
   localparam int COLD_END     = -40;

   typedef struct packed {
      logic signed [tti_pkg::TEMP_W-1:0]  sixteenths;
      logic signed [tti_pkg::WHOLE_W-1:0] whole;
      logic                               clamped;
   } reading_type;

   // Thermistor curve, millivolts per 5-degree step starting at -40 C.
   int curve_mv [33] = '{
      2440, 2420, 2400, 2380, 2350, 2320, 2270, 2230, 2170, 2110, 2050, 1990,
      1920, 1860, 1800, 1740, 1680, 1630, 1590, 1550, 1510, 1480, 1450, 1430,
      1400, 1380, 1370, 1350, 1340, 1330, 1320, 1310, 1300
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [tti_pkg::VOLT_W-1:0]   req_voltage_mv = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [tti_pkg::TEMP_W-1:0]   rsp_temp_sixteenths;
   logic signed [tti_pkg::WHOLE_W-1:0]  rsp_whole_degrees;
   logic                                rsp_clamped;

   reading_type pending_readings [$];
   int          mismatches = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_left = 0;

   thermistor_table_interpolator uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_voltage_mv      (req_voltage_mv),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_temp_sixteenths (rsp_temp_sixteenths),
      .rsp_whole_degrees   (rsp_whole_degrees),
      .rsp_clamped         (rsp_clamped)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // Interpolate the curve: 1/16-degree result floors the fraction, whole degrees truncate.
   function automatic reading_type predict_reading(
      input logic signed [tti_pkg::VOLT_W-1:0] mv);
      reading_type r;
      int v, seg, num, den, base;
      v = int'(mv);
      seg = 0;
      r.clamped = 1'b0;
      if (v >= curve_mv[0]) begin
         r.sixteenths = tti_pkg::TEMP_W'(COLD_END * 16);
         r.whole = tti_pkg::WHOLE_W'(COLD_END);
         r.clamped = 1'b1;
      end else if (v <= curve_mv[CURVE_POINTS-1]) begin
         base = COLD_END + DEG_STEP * (CURVE_POINTS - 1);
         r.sixteenths = tti_pkg::TEMP_W'(base * 16);
         r.whole = tti_pkg::WHOLE_W'(base);
         r.clamped = 1'b1;
      end else begin
         while (!(v <= curve_mv[seg] && v >= curve_mv[seg+1])) seg++;
         num = curve_mv[seg] - v;
         den = curve_mv[seg] - curve_mv[seg+1];
         base = COLD_END + DEG_STEP * seg;
         r.sixteenths = tti_pkg::TEMP_W'(base * 16 + (num * DEG_STEP * 16) / den);
         r.whole = tti_pkg::WHOLE_W'((base * den + num * DEG_STEP) / den);
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is accepted.
   task automatic send_voltage(input logic signed [tti_pkg::VOLT_W-1:0] mv);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_voltage_mv <= mv;
      do @(posedge clock); while (req_stall);
      pending_readings.push_back(predict_reading(mv));
      @(negedge clock);
   endtask

   task automatic drain_readings();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [tti_pkg::VOLT_W-1:0] pick_voltage();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return tti_pkg::VOLT_W'($urandom_range(2439, 1301));
      if (sel < 80) return tti_pkg::VOLT_W'(curve_mv[$urandom_range(32)]);
      if (sel < 85) return tti_pkg::VOLT_W'($urandom_range(2460, 2420));
      if (sel < 90) return tti_pkg::VOLT_W'($urandom_range(1320, 1280));
      return tti_pkg::VOLT_W'($urandom);
   endfunction

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: %0d/16 C, %0d C, clamped %0b",
                        rsp_temp_sixteenths, rsp_whole_degrees, rsp_clamped);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_temp_sixteenths !== want.sixteenths) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("temp_sixteenths: expected %0d, got %0d",
                           want.sixteenths, rsp_temp_sixteenths);
            end
            if (rsp_whole_degrees !== want.whole) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("whole_degrees: expected %0d, got %0d",
                           want.whole, rsp_whole_degrees);
            end
            if (rsp_clamped !== want.clamped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("clamped: expected %0b, got %0b", want.clamped, rsp_clamped);
            end
         end
      end
   end

   // Table ends, field extremes and out-of-range inputs.
   task automatic test_clamp_ends();
      send_voltage(13'sd4095);
      send_voltage(-13'sd4096);
      send_voltage(13'sd2500);
      send_voltage(13'sd2441);
      send_voltage(13'sd2440);
      send_voltage(13'sd1300);
      send_voltage(13'sd1299);
      send_voltage(13'sd0);
      send_voltage(-13'sd1);
      send_voltage(-13'sd2500);
   endtask

   // Inner points, near-end values and the zero crossing.
   task automatic test_inner_points();
      send_voltage(13'sd2439);
      send_voltage(13'sd2420);
      send_voltage(13'sd2430);
      send_voltage(13'sd2200);
      send_voltage(13'sd2171);
      send_voltage(13'sd2180);
      send_voltage(13'sd2160);
      send_voltage(13'sd1990);
      send_voltage(13'sd1500);
      send_voltage(13'sd1305);
      send_voltage(13'sd1301);
      send_voltage(13'sd1310);
      drain_readings();
   endtask

   task automatic test_random_traffic(input int count, input int idle, input int stall);
      idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_voltage(pick_voltage());
      drain_readings();
   endtask

   // Hold off the result side long enough that the block stops taking input.
   task automatic test_long_stall();
      idle_pct = 0;
      stall_pct = 0;
      hold_left = 400;
      repeat (6) send_voltage(pick_voltage());
      drain_readings();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_clamp_ends();
      test_inner_points();
      test_random_traffic(360, 0, 0);
      test_random_traffic(360, 58, 0);
      test_long_stall();
      test_random_traffic(360, 0, 58);
      test_random_traffic(360, 30, 30);
      drain_readings();
      repeat (60) @(negedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
